FILE: rtl/command_frame_builder_crc16_defines.svh
// Assertion helpers shared by the frame builder RTL.
`ifndef COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH
`define COMMAND_FRAME_BUILDER_CRC16_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CFB_ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CFB_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/cfb_pkg.sv
package cfb_pkg;

  localparam int MAX_PAYLOAD = 256;
  localparam int MSP_LIMIT   = 255;
  localparam int LEN_W       = 9;

  localparam logic [LEN_W-1:0] MAX_LEN     = LEN_W'(MAX_PAYLOAD);
  localparam logic [LEN_W-1:0] MSP_MAX_LEN = LEN_W'(MSP_LIMIT);

  localparam logic [15:0] CRC_POLY  = 16'h1021;
  localparam logic [7:0]  FW_MARKER = 8'h2f;
  localparam logic [7:0]  MSP_HDR0  = 8'h24;  // '$'
  localparam logic [7:0]  MSP_HDR1  = 8'h4d;  // 'M'
  localparam logic [7:0]  MSP_HDR2  = 8'h3c;  // '<'

  // job queue, depth must be a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  typedef enum logic {
    PROTO_FW  = 1'b0,
    PROTO_MSP = 1'b1
  } proto_t;

  typedef enum logic [1:0] {
    JOB_ERR,
    JOB_START,
    JOB_DATA
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    proto_t      proto;
    logic [7:0]  cmd;
    logic [15:0] addr;
    logic [7:0]  len_byte;
    logic [7:0]  pay_byte;
    logic        has_pay;   // a payload byte goes out
    logic        trailer;   // check bytes close the frame
  } job_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_ERR,
    BK_H0,
    BK_H1,
    BK_H2,
    BK_H3,
    BK_H4,
    BK_PAY,
    BK_CHK_HI,
    BK_CHK_LO
  } bk_state_t;

  // CRC-16, poly 0x1021, MSB first, one byte
  function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

FILE: rtl/cfb_front.sv
`include "command_frame_builder_crc16_defines.svh"

module cfb_front
  import cfb_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_TDATA_W-1:0] in_tdata,
  input  logic [IN_TUSER_W-1:0] in_tuser,
  input  logic                  q_full,
  output logic                  push,
  output job_t                  push_job
);

  logic             in_frame_r, in_frame_nxt;
  logic [LEN_W-1:0] left_r, left_nxt;
  proto_t           proto_r, proto_nxt;

  logic             start;
  proto_t           proto_in;
  logic [LEN_W-1:0] len;
  logic             len_ok;
  logic [LEN_W-1:0] left_dec;

  assign in_tready = !q_full;
  assign push      = in_tvalid && in_tready;

  assign start    = in_tuser[0];
  assign proto_in = proto_t'(in_tuser[1]);
  assign len      = in_tdata[32:24];

  assign len_ok = (proto_in == PROTO_MSP) ? (len <= MSP_MAX_LEN && len <= MAX_LEN)
                                          : (len != '0 && len <= MAX_LEN);

  assign left_dec = (left_r != '0) ? left_r - LEN_W'(1) : left_r;

  always_comb begin
    push_job.kind     = JOB_DATA;
    push_job.proto    = proto_r;
    push_job.cmd      = in_tdata[7:0];
    push_job.addr     = in_tdata[23:8];
    push_job.len_byte = len[7:0];
    push_job.pay_byte = in_tdata[40:33];
    push_job.has_pay  = 1'b1;
    push_job.trailer  = 1'b0;
    in_frame_nxt      = in_frame_r;
    left_nxt          = left_r;
    proto_nxt         = proto_r;
    priority if (start) begin
      if (!len_ok) begin
        push_job.kind = JOB_ERR;
        in_frame_nxt  = 1'b0;
        left_nxt      = '0;
      end else begin
        push_job.kind  = JOB_START;
        push_job.proto = proto_in;
        proto_nxt      = proto_in;
        if (len == '0) begin
          // empty MSP frame: header and checksum only
          push_job.has_pay = 1'b0;
          push_job.trailer = 1'b1;
          in_frame_nxt     = 1'b0;
          left_nxt         = '0;
        end else begin
          left_nxt         = len - LEN_W'(1);
          push_job.trailer = (len == LEN_W'(1));
          in_frame_nxt     = (len != LEN_W'(1));
        end
      end
    end else if (!in_frame_r) begin
      push_job.kind = JOB_ERR;
    end else begin
      left_nxt         = left_dec;
      push_job.trailer = (left_dec == '0);
      in_frame_nxt     = (left_dec != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      left_r     <= '0;
      proto_r    <= PROTO_FW;
    end else if (push) begin
      in_frame_r <= in_frame_nxt;
      left_r     <= left_nxt;
      proto_r    <= proto_nxt;
    end
  end

  `CFB_ASSERT_NEXT(a_trailer_closes, clk, rst_n, push && push_job.trailer, !in_frame_r, "frame open after trailer")
  `CFB_ASSERT_IMPL(a_open_has_bytes, clk, rst_n, in_frame_r, left_r != '0, "open frame with no bytes left")

endmodule

FILE: rtl/cfb_queue.sv
module cfb_queue
  import cfb_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  job_t push_job,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output job_t head_job
);

  job_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign full       = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_job   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + QCNT_W'(1);
        2'b01:   count_r <= count_r - QCNT_W'(1);
        default: count_r <= count_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

FILE: rtl/cfb_back.sv
`include "command_frame_builder_crc16_defines.svh"

module cfb_back
  import cfb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   head_valid,
  input  job_t                   head_job,
  output logic                   pop,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  bk_state_t   state_r, state_nxt;
  job_t        cur_r;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  xor_r, xor_nxt;

  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_last_r, out_fend_r, out_err_r;

  logic        adv, emit;
  logic        is_fw;
  logic [7:0]  byte_c;
  logic        fend_c, err_c, fold_c, done_c;
  bk_state_t   cont_c, first_c;
  logic [15:0] crc_base;
  logic [7:0]  xor_base;

  assign adv   = !out_valid_r || out_tready;
  assign emit  = (state_r != BK_IDLE) && adv;
  assign is_fw = (cur_r.proto == PROTO_FW);

  // byte and flags of the current step
  always_comb begin
    byte_c = '0;
    fend_c = 1'b0;
    err_c  = 1'b0;
    fold_c = 1'b0;
    done_c = 1'b0;
    cont_c = BK_IDLE;
    unique case (state_r)
      BK_IDLE: begin
        done_c = 1'b0;
      end
      BK_ERR: begin
        err_c  = 1'b1;
        done_c = 1'b1;
      end
      BK_H0: begin
        byte_c = is_fw ? FW_MARKER : MSP_HDR0;
        fold_c = is_fw;
        cont_c = BK_H1;
      end
      BK_H1: begin
        byte_c = is_fw ? cur_r.cmd : MSP_HDR1;
        fold_c = is_fw;
        cont_c = BK_H2;
      end
      BK_H2: begin
        byte_c = is_fw ? cur_r.addr[15:8] : MSP_HDR2;
        fold_c = is_fw;
        cont_c = BK_H3;
      end
      BK_H3: begin
        byte_c = is_fw ? cur_r.addr[7:0] : cur_r.len_byte;
        fold_c = 1'b1;
        cont_c = BK_H4;
      end
      BK_H4: begin
        byte_c = is_fw ? cur_r.len_byte : cur_r.cmd;
        fold_c = 1'b1;
        cont_c = cur_r.has_pay ? BK_PAY : BK_CHK_HI;
      end
      BK_PAY: begin
        byte_c = cur_r.pay_byte;
        fold_c = 1'b1;
        done_c = !cur_r.trailer;
        cont_c = BK_CHK_HI;
      end
      BK_CHK_HI: begin
        byte_c = is_fw ? crc_r[15:8] : xor_r;
        fend_c = !is_fw;
        done_c = !is_fw;
        cont_c = BK_CHK_LO;
      end
      BK_CHK_LO: begin
        byte_c = crc_r[7:0];
        fend_c = 1'b1;
        done_c = 1'b1;
      end
      default: begin
        done_c = 1'b1;
      end
    endcase
  end

  always_comb begin
    unique case (head_job.kind)
      JOB_START: first_c = BK_H0;
      JOB_DATA:  first_c = BK_PAY;
      default:   first_c = BK_ERR;
    endcase
  end

  assign pop = head_valid && ((state_r == BK_IDLE) || (adv && done_c));

  always_comb begin
    state_nxt = state_r;
    priority if (state_r == BK_IDLE) begin
      if (head_valid) begin
        state_nxt = first_c;
      end
    end else if (adv) begin
      if (!done_c) begin
        state_nxt = cont_c;
      end else if (head_valid) begin
        state_nxt = first_c;
      end else begin
        state_nxt = BK_IDLE;
      end
    end
  end

  // marker step restarts both checks
  assign crc_base = (state_r == BK_H0) ? 16'h0000 : crc_r;
  assign xor_base = (state_r == BK_H0) ? 8'h00 : xor_r;
  assign crc_nxt  = (fold_c && is_fw) ? crc_fold(crc_base, byte_c) : crc_base;
  assign xor_nxt  = (fold_c && !is_fw) ? (xor_base ^ byte_c) : xor_base;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      out_valid_r <= 1'b0;
      crc_r       <= '0;
      xor_r       <= '0;
    end else begin
      state_r <= state_nxt;
      if (adv) begin
        out_valid_r <= (state_r != BK_IDLE);
      end
      if (emit) begin
        crc_r <= crc_nxt;
        xor_r <= xor_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur_r <= head_job;
    end
    if (emit) begin
      out_byte_r <= byte_c;
      out_last_r <= done_c;
      out_fend_r <= fend_c;
      out_err_r  <= err_c;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_byte_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = {out_err_r, out_fend_r};

  `CFB_ASSERT_IMPL(a_err_single, clk, rst_n, out_tvalid && out_tuser[1], out_tlast && !out_tuser[0], "error byte not a lone last byte")
  `CFB_ASSERT_IMPL(a_fend_last, clk, rst_n, out_tvalid && out_tuser[0], out_tlast, "check byte not last of its item")
  `CFB_ASSERT_IMPL(a_crc_lo_fw, clk, rst_n, state_r == BK_CHK_LO, cur_r.proto == PROTO_FW, "second check byte on MSP frame")

endmodule

FILE: rtl/command_frame_builder_crc16.sv
// The first byte of an item passes through the job queue, the back-end state and the output register.
// The back end sends one output byte per cycle unless out_tready stalls it; a mid-frame item is one
// payload byte, plus check bytes when it closes the frame, and a frame start adds its header first.
// Input stays ready while the 4-entry job queue has room.
// Reset: rst_n synchronous, active low; clears frame state, checks, queue and output.
module command_frame_builder_crc16
  import cfb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [7:0] command_code, [23:8] address, [32:24] payload_length,
  // [40:33] payload_byte, [47:41] zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [0] frame_start, [1] protocol
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [7:0] out_byte
  output logic [OUT_TDATA_W-1:0] out_tdata,
  output logic                   out_tlast,   // run_last
  // [0] frame_end, [1] length_error
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  // Front end: takes each transaction, checks the length, tracks the open frame
  // and bytes left, and turns the item into one job (error, frame start or
  // payload byte, with a flag for the closing check bytes).
  logic q_full;
  logic push;
  job_t push_job;

  cfb_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_job  (push_job)
  );

  // Short job queue between the two halves, so the input side keeps taking
  // items while a header or trailer is still being sent.
  logic pop;
  logic head_valid;
  job_t head_job;

  cfb_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  // Back end: steps through the bytes of each job, folds them into the running
  // CRC-16 (four-way) or XOR sum (MSP), and drives a registered output stage.
  // The next job is picked up in the same cycle the last byte of the current
  // one is sent, so payload bytes stream at one per cycle while the output is not stalled.
  cfb_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

FILE: bench/command_frame_builder_crc16_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the frame builder. It predicts every output byte
// from the accepted input transactions and compares them in order.
module command_frame_builder_crc16_checker
  import cfb_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   out_tlast,
  input  logic [OUT_TUSER_W-1:0] out_tuser,
  output int                     fail_count,
  output int                     pending_count,
  output int                     item_count,
  output int                     byte_count,
  output int                     frame_count,
  output int                     error_count
);

  typedef struct {
    logic [7:0] value;
    logic       item_last;
    logic       frame_end;
    logic       length_error;
  } frame_byte_t;

  frame_byte_t expected_bytes[$];

  // running copy of the builder's frame state
  logic [15:0]      crc_run;
  logic [7:0]       xor_run;
  logic [LEN_W-1:0] left_run;
  logic             open_run;
  proto_t           proto_run;

  // XMODEM CRC, one bit at a time
  function automatic logic [15:0] crc16_next(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] r;
    logic        fb;
    r = crc;
    for (int k = 7; k >= 0; k--) begin
      fb = r[15] ^ b[k];
      r  = {r[14:0], 1'b0} ^ (fb ? CRC_POLY : 16'h0000);
    end
    return r;
  endfunction

  task automatic push_byte(input logic [7:0] v, input logic fend, input logic err);
    frame_byte_t e;
    e.value        = v;
    e.item_last    = 1'b0;
    e.frame_end    = fend;
    e.length_error = err;
    expected_bytes = {expected_bytes, e};
  endtask

  // a byte covered by the check
  task automatic push_framed(input logic [7:0] v);
    if (proto_run == PROTO_MSP) begin
      xor_run = xor_run ^ v;
    end else begin
      crc_run = crc16_next(crc_run, v);
    end
    push_byte(v, 1'b0, 1'b0);
  endtask

  task automatic push_check_bytes();
    if (proto_run == PROTO_MSP) begin
      push_byte(xor_run, 1'b1, 1'b0);
    end else begin
      push_byte(crc_run[15:8], 1'b0, 1'b0);
      push_byte(crc_run[7:0], 1'b1, 1'b0);
    end
    open_run = 1'b0;
    frame_count++;
  endtask

  task automatic push_payload(input logic [7:0] pb);
    push_framed(pb);
    if (left_run != 0) begin
      left_run = left_run - LEN_W'(1);
    end
    if (left_run == 0) begin
      push_check_bytes();
    end
  endtask

  task automatic push_error();
    push_byte(8'h00, 1'b0, 1'b1);
    error_count++;
  endtask

  task automatic predict_frame_bytes(input logic [IN_TDATA_W-1:0] d,
                                     input logic [IN_TUSER_W-1:0] u);
    logic             start;
    proto_t           proto;
    logic [7:0]       cmd;
    logic [15:0]      addr;
    logic [LEN_W-1:0] len;
    logic [7:0]       pb;
    logic             legal;
    frame_byte_t      tail;
    start = u[0];
    proto = proto_t'(u[1]);
    cmd   = d[7:0];
    addr  = d[23:8];
    len   = d[32:24];
    pb    = d[40:33];
    if (start) begin
      if (proto == PROTO_MSP) begin
        legal = (len <= MSP_MAX_LEN) && (len <= MAX_LEN);
      end else begin
        legal = (len != 0) && (len <= MAX_LEN);
      end
      if (!legal) begin
        // bad length also drops whatever frame was open
        open_run = 1'b0;
        left_run = '0;
        push_error();
      end else begin
        open_run  = 1'b1;
        proto_run = proto;
        left_run  = len;
        crc_run   = 16'h0000;
        xor_run   = 8'h00;
        if (proto == PROTO_MSP) begin
          push_byte(MSP_HDR0, 1'b0, 1'b0);
          push_byte(MSP_HDR1, 1'b0, 1'b0);
          push_byte(MSP_HDR2, 1'b0, 1'b0);
          push_framed(len[7:0]);
          push_framed(cmd);
          if (len == 0) begin
            push_check_bytes();
          end else begin
            push_payload(pb);
          end
        end else begin
          push_framed(FW_MARKER);
          push_framed(cmd);
          push_framed(addr[15:8]);
          push_framed(addr[7:0]);
          push_framed(len[7:0]);
          push_payload(pb);
        end
      end
    end else if (!open_run) begin
      push_error();
    end else begin
      push_payload(pb);
    end
    tail = expected_bytes[expected_bytes.size() - 1];
    tail.item_last = 1'b1;
    expected_bytes[expected_bytes.size() - 1] = tail;
  endtask

  task automatic report_mismatch(input string what, input logic [7:0] got_v,
                                 input logic [7:0] want_v);
    if (fail_count < 100) begin
      $display("%0t ns: byte %0d %s: got %h, expected %h", $time, byte_count, what,
               got_v, want_v);
    end
    fail_count++;
  endtask

  always @(posedge clk) begin
    frame_byte_t want;
    if (!rst_n) begin
      expected_bytes.delete();
      crc_run     = 16'h0000;
      xor_run     = 8'h00;
      left_run    = '0;
      open_run    = 1'b0;
      proto_run   = PROTO_FW;
      fail_count  = 0;
      item_count  = 0;
      byte_count  = 0;
      frame_count = 0;
      error_count = 0;
    end else begin
      if (in_tvalid && in_tready) begin
        predict_frame_bytes(in_tdata, in_tuser);
        item_count++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch("arrived with nothing expected", out_tdata, 8'h00);
        end else begin
          want = expected_bytes.pop_front();
          if (out_tdata !== want.value) begin
            report_mismatch("data", out_tdata, want.value);
          end
          if (out_tlast !== want.item_last) begin
            report_mismatch("tlast", {7'b0, out_tlast}, {7'b0, want.item_last});
          end
          if (out_tuser[0] !== want.frame_end) begin
            report_mismatch("frame end", {7'b0, out_tuser[0]}, {7'b0, want.frame_end});
          end
          if (out_tuser[1] !== want.length_error) begin
            report_mismatch("length error", {7'b0, out_tuser[1]},
                            {7'b0, want.length_error});
          end
        end
        byte_count++;
      end
    end
    pending_count = expected_bytes.size();
  end

endmodule

FILE: bench/command_frame_builder_crc16_test.sv
`timescale 1ns / 1ps

// Stimulus and verdict for the command frame builder. A directed opening
// covers the field extremes and the corner cases, then random frames follow.
// All prediction and comparison lives in the checker module.
module command_frame_builder_crc16_test;
  import cfb_pkg::*;

  localparam int RANDOM_ITEMS = 100;
  localparam int QUIET_ITEMS  = 25;   // tail of the random part with no idling
  localparam int TAIL_CYCLES  = 20;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;
  logic [IN_TUSER_W-1:0]  in_tuser;
  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tlast;
  logic [OUT_TUSER_W-1:0] out_tuser;

  int fail_count;
  int pending_count;
  int item_count;
  int byte_count;
  int frame_count;
  int error_count;

  // idling control shared by both sides
  logic quiet     = 1'b0;
  int   gap_pct   = 0;
  int   stall_pct = 0;
  int   stall_left = 0;
  int   sent_items = 0;

  always #5 clk = ~clk;

  command_frame_builder_crc16 DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  command_frame_builder_crc16_checker frame_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .in_tuser      (in_tuser),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .fail_count    (fail_count),
    .pending_count (pending_count),
    .item_count    (item_count),
    .byte_count    (byte_count),
    .frame_count   (frame_count),
    .error_count   (error_count)
  );

  // Drives one input transaction from the falling edge, with an optional burst
  // of idle cycles ahead of it, and returns once it has been accepted.
  task automatic send_item(input logic start, input proto_t proto, input logic [7:0] cmd,
                           input logic [15:0] addr, input logic [LEN_W-1:0] len,
                           input logic [7:0] pb);
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'b0, pb, len, addr, cmd};
    in_tuser  <= {proto, start};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_items++;
  endtask

  // frame start with random header and first payload byte
  task automatic send_start(input proto_t proto, input logic [LEN_W-1:0] len);
    send_item(1'b1, proto, 8'($urandom), 16'($urandom), len, 8'($urandom));
  endtask

  // mid-frame transaction; header fields are junk and must be ignored
  task automatic send_data();
    send_item(1'b0, proto_t'($urandom_range(0, 1)), 8'($urandom), 16'($urandom),
              9'($urandom), 8'($urandom));
  endtask

  // Receiver back-pressure: random stall bursts, rate changed now and then.
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (quiet) begin
        out_tready <= 1'b1;
      end else if (stall_left > 0) begin
        out_tready <= 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 99) < stall_pct) begin
        out_tready <= 1'b0;
        stall_left = $urandom_range(0, 13);
      end else begin
        out_tready <= 1'b1;
      end
      if ($urandom_range(0, 63) == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 10;
          default: stall_pct = 40;
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("command_frame_builder_crc16_test NOT OK");
    $finish;
  end

  initial begin
    int               first_random;
    int               kind;
    int               cut;
    proto_t           proto;
    logic [LEN_W-1:0] len;

    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    gap_pct   = 20;
    stall_pct = 10;
    // payload transaction with no frame open
    send_item(1'b0, PROTO_FW, 8'h00, 16'h0000, 9'd0, 8'h00);
    // shortest four-way frames, all-zero and all-one fields
    send_item(1'b1, PROTO_FW, 8'h00, 16'h0000, 9'd1, 8'h00);
    send_item(1'b1, PROTO_FW, 8'hff, 16'hffff, 9'd1, 8'hff);
    // illegal lengths: zero for four-way, above the maximum for both
    send_item(1'b1, PROTO_FW, 8'h5a, 16'h1234, 9'd0, 8'h00);
    send_item(1'b1, PROTO_FW, 8'($urandom), 16'($urandom), 9'd257, 8'($urandom));
    send_item(1'b1, PROTO_MSP, 8'($urandom), 16'($urandom), 9'd511, 8'($urandom));
    send_item(1'b1, PROTO_MSP, 8'hff, 16'($urandom), 9'd256, 8'($urandom));
    // empty MSP frame: whole frame in one go, payload byte ignored
    send_item(1'b1, PROTO_MSP, 8'h00, 16'($urandom), 9'd0, 8'hff);
    // short MSP frame completed normally
    send_start(PROTO_MSP, 9'd2);
    send_data();
    // four-way frame cut short by an MSP restart
    send_start(PROTO_FW, 9'd3);
    send_data();
    send_start(PROTO_MSP, 9'd1);
    // longest four-way length (sent as 0), then restarted
    send_start(PROTO_FW, 9'd256);
    send_data();
    send_start(PROTO_FW, 9'd2);
    send_data();
    // longest MSP length, then a bad start closes it; the next byte is stray
    send_start(PROTO_MSP, 9'd255);
    send_data();
    send_start(PROTO_FW, 9'd300);
    send_data();

    // --- random: mostly well-formed frames, some broken ones and noise ---
    first_random = sent_items;
    while (sent_items - first_random < RANDOM_ITEMS) begin
      if (sent_items - first_random >= RANDOM_ITEMS - QUIET_ITEMS) begin
        quiet = 1'b1;
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 20;
        default: gap_pct = 60;
      endcase
      kind  = $urandom_range(0, 99);
      proto = proto_t'($urandom_range(0, 1));
      if (kind < 78) begin
        if ($urandom_range(0, 99) < 85) begin
          len = 9'($urandom_range(proto == PROTO_MSP ? 0 : 1, 6));
        end else begin
          len = 9'($urandom_range(7, 40));
        end
        send_start(proto, len);
        for (int i = 1; i < len; i++) begin
          send_data();
        end
      end else if (kind < 88) begin
        // truncated frame; whatever comes next restarts or continues it
        len = 9'($urandom_range(2, 12));
        send_start(proto, len);
        cut = $urandom_range(0, len - 2);
        repeat (cut) send_data();
      end else if (kind < 95) begin
        if (proto == PROTO_FW && $urandom_range(0, 1) == 0) begin
          len = 9'd0;
        end else begin
          len = 9'($urandom_range(proto == PROTO_MSP ? 256 : 257, 511));
        end
        send_start(proto, len);
      end else begin
        send_data();
      end
    end
    @(negedge clk);
    in_tvalid <= 1'b0;

    // drain, then allow the pipeline to settle
    while (pending_count != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Covered %0d input transactions and %0d output bytes:", item_count, byte_count);
    $display("  %0d frames closed with check bytes, %0d error results", frame_count,
             error_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("command_frame_builder_crc16_test OK");
    end else begin
      $display("command_frame_builder_crc16_test NOT OK");
    end
    $finish;
  end

endmodule
